[sv/lti_pkg.sv]
// shared types and constants of the lock target map interpolator
`timescale 1ns / 1ps
package lti_pkg;

  // input beat operation codes
  typedef enum logic [1:0] {
    OP_EVAL   = 2'd0,
    OP_WR_TBP = 2'd1,
    OP_WR_SBP = 2'd2,
    OP_WR_MAP = 2'd3
  } op_t;

  // drive modes
  localparam logic [2:0] MODE_FRONT  = 3'd0;
  localparam logic [2:0] MODE_HALF   = 3'd1;
  localparam logic [2:0] MODE_SIXTY  = 3'd2;
  localparam logic [2:0] MODE_SEVENT = 3'd3;
  localparam logic [2:0] MODE_MAP    = 3'd4;

  // configuration register indexes
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] CFG_DRIVE_MODE  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_PEDAL_TH    = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SPD_UNDER   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_SPD_ABOVE   = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_FORCE_ALLOW = 3'd4;
  localparam int CFG_DW = 9;

  // fixed lock targets
  localparam logic [6:0] PCT_FULL  = 7'd100;
  localparam logic [6:0] PCT_SIXTY = 7'd40;
  localparam logic [6:0] PCT_SEVEN = 7'd30;
  localparam logic [6:0] PCT_ZERO  = 7'd0;

  // datapath widths
  localparam int MAP_W    = 7;
  localparam int CNT_W    = 5;
  localparam int DIV_BITS = 17;
  localparam logic signed [17:0] RATIO_POS = 18'sh1FFFF;
  localparam logic signed [17:0] RATIO_NEG = 18'sh20000;

  typedef struct packed {
    logic [2:0] drive_mode;
    logic [7:0] pedal_min;
    logic [8:0] speed_under;
    logic [8:0] speed_above;
    logic       force_allowed;
  } cfg_t;

  typedef struct packed {
    logic cap;
    logic scan_step;
    logic div_step;
    logic rd_step;
    logic mul_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic quick;
    logic scan_last;
    logic need_div;
    logic div_last;
    logic rd_last;
    logic mul_last;
    logic ax;
    logic out_free;
  } sts_t;

endpackage

[sv/lock_target_map_interpolator.sv]
// Table writes and fixed-mode beats go from accept to the done state, which loads the result
// into the output register once that is free. Expert map beats scan the throttle and then the
// speed breakpoints, each scan followed by a ratio division when needed, then read the four
// map cells, multiply and interpolate, and load the output. One beat is in work at a time;
// the next is taken the cycle after the result is loaded.
// Reset (synchronous, rst_n low) clears configuration and control; tables stay unwritten.
`timescale 1ns / 1ps
module lock_target_map_interpolator #(
  parameter int THROTTLE_POINTS = 8,
  parameter int SPEED_POINTS    = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [lti_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [lti_pkg::CFG_DW-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [5:0]                    in_table_index,
  input  logic [8:0]                    in_table_value,
  input  logic [7:0]                    in_pedal,
  input  logic signed [9:0]             in_vehicle_speed,
  input  logic                          in_force_request,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [6:0]                    out_lock_percent,
  output logic                          out_lock_active
);
  import lti_pkg::*;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DRIVE_MODE:  cfg_r.drive_mode    <= cfg_wdata[2:0];
        CFG_PEDAL_TH:    cfg_r.pedal_min     <= cfg_wdata[7:0];
        CFG_SPD_UNDER:   cfg_r.speed_under   <= cfg_wdata[8:0];
        CFG_SPD_ABOVE:   cfg_r.speed_above   <= cfg_wdata[8:0];
        CFG_FORCE_ALLOW: cfg_r.force_allowed <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  lti_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  lti_dp #(
    .THROTTLE_POINTS (THROTTLE_POINTS),
    .SPEED_POINTS    (SPEED_POINTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .sts              (sts),
    .in_opcode        (in_opcode),
    .in_table_index   (in_table_index),
    .in_table_value   (in_table_value),
    .in_pedal         (in_pedal),
    .in_vehicle_speed (in_vehicle_speed),
    .in_force_request (in_force_request),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_lock_percent (out_lock_percent),
    .out_lock_active  (out_lock_active)
  );

  // one beat in work at a time
  a_one_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while a beat is in work");

  // a new result reopens the input
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result loaded but input still stalled");

  // lock target stays in range
  a_pct_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_lock_percent <= PCT_FULL))
    else $error("lock target above full lock");

  // only one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(cmd))
    else $error("controller issued overlapping commands");
endmodule

[sv/lti_ram.sv]
// generic single port ram with registered read
`timescale 1ns / 1ps
module lti_ram #(
  parameter int WIDTH = 7,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    rdata_r <= mem_r[addr];
  end

  assign rdata = rdata_r;
endmodule

[sv/lti_dp.sv]
// datapath: tables, segment search, ratio divider, interpolation, output register
`timescale 1ns / 1ps
module lti_dp #(
  parameter int THROTTLE_POINTS = 8,
  parameter int SPEED_POINTS    = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lti_pkg::cfg_t      cfg,
  input  lti_pkg::cmd_t      cmd,
  output lti_pkg::sts_t      sts,
  input  logic [1:0]         in_opcode,
  input  logic [5:0]         in_table_index,
  input  logic [8:0]         in_table_value,
  input  logic [7:0]         in_pedal,
  input  logic signed [9:0]  in_vehicle_speed,
  input  logic               in_force_request,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [6:0]         out_lock_percent,
  output logic               out_lock_active
);
  import lti_pkg::*;

  localparam int TIW       = $clog2(THROTTLE_POINTS);
  localparam int SIW       = $clog2(SPEED_POINTS);
  localparam int MAP_CELLS = THROTTLE_POINTS * SPEED_POINTS;
  localparam int AW        = $clog2(MAP_CELLS);
  localparam int EW        = (AW > 6) ? AW : 6;

  // tables
  logic [6:0] tbp_r [THROTTLE_POINTS];
  logic [8:0] sbp_r [SPEED_POINTS];

  // item registers
  logic [6:0] xt_r;
  logic [8:0] xs_r;
  logic [6:0] pct_r;
  logic       act_r;

  // sequencing
  logic [CNT_W-1:0] k_r;
  logic             ax_r;

  // search state
  logic             found_r;
  logic [8:0]       prev_r, lo_r, hi_r;
  logic [CNT_W-1:0] idx_r;
  logic [TIW-1:0]   t0_r, t1_r;
  logic [SIW-1:0]   s0_r, s1_r;
  logic signed [17:0] tr_r, sr_r;

  // divider
  logic [9:0]          rem_r;
  logic [8:0]          d_r;
  logic [DIV_BITS-1:0] q_r;
  logic                neg_r;

  // interpolation
  logic [MAP_W-1:0]   cell_r [4];
  logic signed [45:0] prod_r;
  logic signed [26:0] v0_r, v1_r;

  // output register
  logic       out_valid_r;
  logic [6:0] out_pct_r;
  logic       out_act_r;

  // lock conditions and fixed mode answers
  logic       pedal_ok, speed_pass, active, is_eval, forced;
  logic [6:0] quick_pct;

  always_comb begin
    is_eval  = (in_opcode == OP_EVAL);
    forced   = cfg.force_allowed && in_force_request;
    pedal_ok = (cfg.pedal_min == 8'd0) || (in_pedal >= cfg.pedal_min);
    speed_pass = (cfg.speed_under == 9'd0) ||
                 (in_vehicle_speed <= $signed({1'b0, cfg.speed_under})) ||
                 (in_vehicle_speed >= $signed({1'b0, cfg.speed_above}));
    active   = (cfg.drive_mode == MODE_MAP) || (pedal_ok && speed_pass);
    quick_pct = PCT_ZERO;
    if (is_eval) begin
      if (forced) begin
        quick_pct = PCT_FULL;
      end else if (active) begin
        case (cfg.drive_mode)
          MODE_HALF:   quick_pct = PCT_FULL;
          MODE_SIXTY:  quick_pct = PCT_SIXTY;
          MODE_SEVENT: quick_pct = PCT_SEVEN;
          default:     quick_pct = PCT_ZERO;
        endcase
      end
    end
  end

  // table write decode
  logic [EW-1:0] idx_ext;
  logic          wr_t, wr_s, wr_m;

  always_comb begin
    idx_ext = EW'(in_table_index);
    wr_t = cmd.cap && (in_opcode == OP_WR_TBP) && (int'(in_table_index) < THROTTLE_POINTS);
    wr_s = cmd.cap && (in_opcode == OP_WR_SBP) && (int'(in_table_index) < SPEED_POINTS);
    wr_m = cmd.cap && (in_opcode == OP_WR_MAP) && (int'(in_table_index) < MAP_CELLS);
  end

  // segment search step
  logic [8:0]       x, bpv, f_lo, f_hi;
  logic [CNT_W-1:0] nlast, f_idx, km1;
  logic             hit, f_found, ge_last, dpos, sat, scan_last, need_div;
  logic signed [9:0] num, dif;
  logic [8:0]       mag;
  logic [CNT_W-1:0] i0, i1;
  logic signed [17:0] ratio0;

  always_comb begin
    x     = ax_r ? xs_r : {2'b0, xt_r};
    bpv   = ax_r ? sbp_r[k_r[SIW-1:0]] : {2'b0, tbp_r[k_r[TIW-1:0]]};
    nlast = ax_r ? CNT_W'(SPEED_POINTS - 1) : CNT_W'(THROTTLE_POINTS - 1);
    km1   = k_r - CNT_W'(1);
    scan_last = (k_r == nlast);
    hit     = (k_r != '0) && (x <= bpv);
    f_found = found_r || hit;
    f_lo    = found_r ? lo_r : prev_r;
    f_hi    = found_r ? hi_r : bpv;
    f_idx   = found_r ? idx_r : km1;
    ge_last = (x >= bpv);
    num  = $signed({1'b0, x}) - $signed({1'b0, f_lo});
    dif  = $signed({1'b0, f_hi}) - $signed({1'b0, f_lo});
    mag  = num[9] ? 9'(-num) : num[8:0];
    dpos = !dif[9] && (dif != 10'sd0);
    sat  = ({1'b0, mag} >= {dif[8:0], 1'b0});
    need_div = !ge_last && f_found && dpos && !sat;
    // segment indexes and the ratio when no division runs
    ratio0 = 18'sd0;
    if (ge_last) begin
      i0 = nlast;
      i1 = nlast;
    end else if (f_found) begin
      i0 = f_idx;
      i1 = f_idx + CNT_W'(1);
      if (dpos && sat) begin
        ratio0 = num[9] ? RATIO_NEG : RATIO_POS;
      end
    end else begin
      i0 = '0;
      i1 = '0;
    end
  end

  // divider step
  logic                ge_d;
  logic [9:0]          rsub;
  logic [DIV_BITS-1:0] q_nxt;
  logic signed [17:0]  ratio_div;

  always_comb begin
    ge_d  = (rem_r >= {1'b0, d_r});
    rsub  = ge_d ? (rem_r - {1'b0, d_r}) : rem_r;
    q_nxt = {q_r[DIV_BITS-2:0], ge_d};
    ratio_div = neg_r ? -$signed({1'b0, q_nxt}) : $signed({1'b0, q_nxt});
  end

  // map read address
  logic [TIW-1:0] row;
  logic [SIW-1:0] col;
  logic [AW-1:0]  rd_addr, ram_addr;
  logic [MAP_W-1:0] ram_rdata;

  always_comb begin
    row = k_r[1] ? t1_r : t0_r;
    col = k_r[0] ? s1_r : s0_r;
    rd_addr  = AW'(int'(row) * SPEED_POINTS + int'(col));
    ram_addr = cmd.cap ? idx_ext[AW-1:0] : rd_addr;
  end

  lti_ram #(.WIDTH(MAP_W), .DEPTH(MAP_CELLS)) u_map (
    .clk   (clk),
    .we    (wr_m),
    .addr  (ram_addr),
    .wdata (in_table_value[MAP_W-1:0]),
    .rdata (ram_rdata)
  );

  // shared multiplier and interpolation sums
  logic signed [7:0]  d0, d1;
  logic signed [27:0] vdiff, mul_a;
  logic signed [17:0] mul_b;
  logic signed [45:0] mul_p;
  logic signed [26:0] vsum;
  logic signed [47:0] vfin;
  logic [6:0]         map_pct;

  always_comb begin
    d0    = $signed({1'b0, cell_r[1]}) - $signed({1'b0, cell_r[0]});
    d1    = $signed({1'b0, cell_r[3]}) - $signed({1'b0, cell_r[2]});
    vdiff = 28'(v1_r) - 28'(v0_r);
    mul_a = (k_r == CNT_W'(3)) ? vdiff : ((k_r == CNT_W'(0)) ? 28'(d0) : 28'(d1));
    mul_b = (k_r == CNT_W'(3)) ? tr_r : sr_r;
    mul_p = mul_a * mul_b;
    vsum  = $signed({4'b0, (k_r == CNT_W'(1)) ? cell_r[0] : cell_r[2], 16'b0})
            + $signed(prod_r[26:0]);
    vfin  = (48'(v0_r) <<< 16) + 48'(prod_r);
    if (vfin[47]) begin
      map_pct = PCT_ZERO;
    end else if (vfin[46:32] >= 15'd100) begin
      map_pct = PCT_FULL;
    end else begin
      map_pct = vfin[38:32];
    end
  end

  // sequencing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      ax_r    <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.cap) begin
      k_r     <= '0;
      ax_r    <= 1'b0;
      found_r <= 1'b0;
    end else if (cmd.scan_step) begin
      if (scan_last) begin
        k_r     <= need_div ? CNT_W'(DIV_BITS - 1) : '0;
        found_r <= 1'b0;
        if (!need_div) begin
          ax_r <= 1'b1;
        end
      end else begin
        k_r <= k_r + CNT_W'(1);
        if (hit && !found_r) begin
          found_r <= 1'b1;
        end
      end
    end else if (cmd.div_step) begin
      if (k_r == '0) begin
        ax_r <= 1'b1;
      end else begin
        k_r <= k_r - CNT_W'(1);
      end
    end else if (cmd.rd_step || cmd.mul_step) begin
      k_r <= (k_r == CNT_W'(4)) ? '0 : k_r + CNT_W'(1);
    end
  end

  // table writes and item capture
  always_ff @(posedge clk) begin
    if (wr_t) begin
      tbp_r[in_table_index[TIW-1:0]] <= in_table_value[6:0];
    end
    if (wr_s) begin
      sbp_r[in_table_index[SIW-1:0]] <= in_table_value;
    end
    if (cmd.cap) begin
      xt_r  <= (in_pedal > 8'd100) ? 7'd100 : in_pedal[6:0];
      xs_r  <= in_vehicle_speed[9] ? 9'd0 : in_vehicle_speed[8:0];
      pct_r <= quick_pct;
      act_r <= is_eval && active;
    end else if (cmd.mul_step && (k_r == CNT_W'(4))) begin
      pct_r <= map_pct;
    end
  end

  // search, divider and interpolation payload
  always_ff @(posedge clk) begin
    if (cmd.scan_step) begin
      prev_r <= bpv;
      if (hit && !found_r) begin
        lo_r  <= prev_r;
        hi_r  <= bpv;
        idx_r <= km1;
      end
      if (scan_last) begin
        rem_r <= {1'b0, mag};
        d_r   <= dif[8:0];
        neg_r <= num[9];
        q_r   <= '0;
        if (ax_r) begin
          s0_r <= i0[SIW-1:0];
          s1_r <= i1[SIW-1:0];
          sr_r <= ratio0;
        end else begin
          t0_r <= i0[TIW-1:0];
          t1_r <= i1[TIW-1:0];
          tr_r <= ratio0;
        end
      end
    end
    if (cmd.div_step) begin
      rem_r <= {rsub[8:0], 1'b0};
      q_r   <= q_nxt;
      if (k_r == '0) begin
        if (ax_r) begin
          sr_r <= ratio_div;
        end else begin
          tr_r <= ratio_div;
        end
      end
    end
    if (cmd.rd_step && (k_r != '0)) begin
      cell_r[km1[1:0]] <= ram_rdata;
    end
    if (cmd.mul_step) begin
      if (k_r == CNT_W'(0) || k_r == CNT_W'(1) || k_r == CNT_W'(3)) begin
        prod_r <= mul_p;
      end
      if (k_r == CNT_W'(1)) begin
        v0_r <= vsum;
      end
      if (k_r == CNT_W'(2)) begin
        v1_r <= vsum;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_pct_r <= pct_r;
      out_act_r <= act_r;
    end
  end

  // status to the controller
  always_comb begin
    sts.quick     = !is_eval || forced || (cfg.drive_mode != MODE_MAP);
    sts.scan_last = scan_last;
    sts.need_div  = need_div;
    sts.div_last  = (k_r == '0);
    sts.rd_last   = (k_r == CNT_W'(4));
    sts.mul_last  = (k_r == CNT_W'(4));
    sts.ax        = ax_r;
    sts.out_free  = !out_valid_r || !out_stall;
  end

  assign out_valid        = out_valid_r;
  assign out_lock_percent = out_pct_r;
  assign out_lock_active  = out_act_r;
endmodule

[sv/lti_ctrl.sv]
// controller state machine sequencing search, divide, map read and interpolation
`timescale 1ns / 1ps
module lti_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  lti_pkg::sts_t sts,
  output lti_pkg::cmd_t cmd
);
  import lti_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_SCAN = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_RD   = 6'b001000,
    ST_MUL  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t st_r, st_nxt;

  // next state and commands
  always_comb begin
    st_nxt   = st_r;
    cmd      = '0;
    in_stall = 1'b1;
    case (st_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.cap = 1'b1;
          st_nxt  = sts.quick ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_last) begin
          if (sts.need_div) begin
            st_nxt = ST_DIV;
          end else begin
            st_nxt = sts.ax ? ST_RD : ST_SCAN;
          end
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          st_nxt = sts.ax ? ST_RD : ST_SCAN;
        end
      end
      ST_RD: begin
        cmd.rd_step = 1'b1;
        if (sts.rd_last) begin
          st_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
        if (sts.mul_last) begin
          st_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          st_nxt       = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end
endmodule
